>>> hdl/mndt_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note duration tracker package
// Shared types, codes and constants for the note duration tracker.
// ----------------------------------------------------------------------------
package mndt_pkg;

  localparam int NOTE_SLOTS_DEF = 128;

  // Field widths fixed by the event format.
  localparam int DELTA_W  = 28;
  localparam int STATUS_W = 8;
  localparam int DATA_W   = 7;
  localparam int TEMPO_W  = 24;
  localparam int TICK_W   = 32;
  localparam int TIME_W   = 32;
  localparam int TPQ_W    = 15;

  // Product of ticks and tempo, and the one-bit-per-cycle divider over it.
  localparam int DIVIDEND_W = TICK_W + TEMPO_W;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_QUARTER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANSPOSE_OFFSET  = 1'b1;

  localparam logic [TPQ_W-1:0]    TPQ_RESET   = 15'd480;
  localparam logic [TEMPO_W-1:0]  TEMPO_RESET = 24'd500000;

  localparam logic [STATUS_W-1:0] STATUS_META     = 8'hFF;
  localparam logic [STATUS_W-1:0] KIND_MASK       = 8'hF0;
  localparam logic [STATUS_W-1:0] KIND_NOTE_ON    = 8'h90;
  localparam logic [STATUS_W-1:0] KIND_NOTE_OFF   = 8'h80;
  localparam logic [DATA_W-1:0]   META_TYPE_TEMPO = 7'h51;
  localparam logic [DATA_W-1:0]   META_LEN_TEMPO  = 7'h03;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an input word and advance the tick count
    logic mul_load;  // load the tick-tempo product into the divider
    logic div_step;  // one restoring division step
    logic commit;    // update the note table and tempo, emit a result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic emit_needed;
    logic out_full;
  } sts_t;

endpackage

>>> hdl/mndt_ctrl.sv
// ----------------------------------------------------------------------------
// Note duration tracker controller
// Sequences capture, multiply, serial divide and commit for each event.
// ----------------------------------------------------------------------------
module mndt_ctrl
  import mndt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // A finished note must wait until the output register is free.
        if (!(sts.emit_needed && sts.out_full)) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MUL:  cmd.mul_load = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.commit   = !(sts.emit_needed && sts.out_full);
    endcase
  end

endmodule

>>> hdl/mndt_dp.sv
// ----------------------------------------------------------------------------
// Note duration tracker datapath
// Event decode, tick count, tempo, multiplier, serial divider and note table.
// ----------------------------------------------------------------------------
module mndt_dp
  import mndt_pkg::*;
#(
  parameter int NOTE_SLOTS = NOTE_SLOTS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TPQ_W-1:0]      cfg_wdata,
  input  logic [DELTA_W-1:0]    ev_delta,
  input  logic                  has_status,
  input  logic [STATUS_W-1:0]   status_byte,
  input  logic [DATA_W-1:0]     data_one,
  input  logic [DATA_W-1:0]     data_two,
  input  logic [TEMPO_W-1:0]    tempo_value,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [DATA_W-1:0]     note_number,
  output logic [DATA_W-1:0]     note_velocity,
  output logic [TIME_W-1:0]     onset_time,
  output logic [TIME_W-1:0]     hold_time,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int IDX_W  = $clog2(NOTE_SLOTS);
  localparam int SLOT_W = DATA_W + TIME_W;

  logic [TPQ_W-1:0]      tpq_r;
  logic [DATA_W-1:0]     transpose_r;
  logic [TICK_W-1:0]     tick_r;
  logic [STATUS_W-1:0]   rstat_r;
  logic [TEMPO_W-1:0]    tempo_r;
  logic [NOTE_SLOTS-1:0] valid_r;

  logic [DATA_W-1:0]     note_r;
  logic [DATA_W-1:0]     vel_r;
  logic [TEMPO_W-1:0]    tval_r;
  logic                  is_tempo_r;
  logic                  is_on_r;
  logic                  is_end_r;

  logic [DIVIDEND_W-1:0] dvd_r;
  logic [TPQ_W-1:0]      rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SLOT_W-1:0]     rd_r;
  logic                  out_valid_r;

  logic [SLOT_W-1:0]     mem [NOTE_SLOTS];

  // Event decode with running status.
  logic                  use_new;
  logic [STATUS_W-1:0]   status;
  logic [STATUS_W-1:0]   kind;
  logic                  dec_tempo;
  logic                  dec_on;
  logic                  dec_end;

  always_comb begin
    use_new   = has_status && status_byte[STATUS_W-1];
    status    = use_new ? status_byte : rstat_r;
    kind      = status & KIND_MASK;
    dec_tempo = (status == STATUS_META) && (data_one == META_TYPE_TEMPO) &&
                (data_two == META_LEN_TEMPO);
    dec_on    = !dec_tempo && (kind == KIND_NOTE_ON) && (data_two != '0);
    dec_end   = !dec_tempo && !dec_on &&
                ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON));
  end

  // Restoring division step: one quotient bit per cycle, shifted into dvd_r.
  logic [DIVIDEND_W-1:0] prod;
  logic [TPQ_W:0]        trial;
  logic [TPQ_W:0]        diff;
  logic                  q_bit;

  assign prod  = tick_r * tempo_r;
  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, tpq_r};
  assign q_bit = (trial >= {1'b0, tpq_r});

  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] rd_start;
  logic [DATA_W-1:0] rd_vel;
  logic              note_valid;

  assign now        = dvd_r[TIME_W-1:0];
  assign rd_start   = rd_r[TIME_W-1:0];
  assign rd_vel     = rd_r[SLOT_W-1:TIME_W];
  assign note_valid = valid_r[note_r[IDX_W-1:0]];

  assign sts.div_last    = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sts.emit_needed = is_end_r && note_valid;
  assign sts.out_full    = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r       <= TPQ_RESET;
      transpose_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TICKS_PER_QUARTER: tpq_r       <= cfg_wdata;
        CFG_TRANSPOSE_OFFSET:  transpose_r <= cfg_wdata[DATA_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      rstat_r <= '0;
      tempo_r <= TEMPO_RESET;
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cmd.load) begin
        tick_r <= tick_r + TICK_W'(ev_delta);
        if (use_new) rstat_r <= status_byte;
      end
      if (cmd.mul_load) cnt_r <= '0;
      if (cmd.div_step) cnt_r <= cnt_r + 1'b1;
      if (cmd.commit) begin
        if (is_tempo_r) tempo_r <= tval_r;
        if (is_on_r) valid_r[note_r[IDX_W-1:0]] <= 1'b1;
        if (sts.emit_needed) valid_r[note_r[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      note_r     <= data_one + transpose_r;
      vel_r      <= data_two;
      tval_r     <= tempo_value;
      is_tempo_r <= dec_tempo;
      is_on_r    <= dec_on;
      is_end_r   <= dec_end;
    end
    if (cmd.mul_load) begin
      dvd_r <= prod;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], q_bit};
      rem_r <= q_bit ? diff[TPQ_W-1:0] : trial[TPQ_W-1:0];
    end
  end

  // Note table: velocity and start time, read continuously at the event's note.
  always_ff @(posedge clk) begin
    if (cmd.commit && is_on_r) mem[note_r[IDX_W-1:0]] <= {vel_r, now};
    rd_r <= mem[note_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && sts.emit_needed) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && sts.emit_needed) begin
      note_number   <= note_r;
      note_velocity <= rd_vel;
      onset_time    <= rd_start;
      hold_time     <= now - rd_start;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(sts.emit_needed && sts.out_full))
    else $error("result committed while output register still full");

  a_on_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && is_on_r |=> valid_r[$past(note_r[IDX_W-1:0])])
    else $error("note-on did not mark its slot active");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && sts.emit_needed |=> !valid_r[$past(note_r[IDX_W-1:0])] && out_valid_r)
    else $error("finished note not cleared or not presented");

  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> cnt_r == CNT_W'(DIV_STEPS))
    else $error("commit before all division steps were done");

endmodule

>>> hdl/midi_note_duration_tracker.sv
// ----------------------------------------------------------------------------
// MIDI note duration tracker
// Pairs note-on and note-off events of a framed MIDI track and reports
// finished notes with start time and duration in microseconds.
// ----------------------------------------------------------------------------
// One event word enters on the in_ stream; a finished note leaves as one word
// on the out_ stream, and most events produce no output at all. Each event
// adds its delta to the tick count, then the absolute time is found as
// ticks times tempo divided by ticks per quarter: the product is registered
// first, then the one-bit-per-cycle divider sets the pace, and a new event
// is accepted only after the last one has been committed.
// in_tready is high only while the block waits for an event. The output
// word sits in a register, so a stalled receiver does not hold up events that
// produce no result; only an event that finishes a note while the previous
// result is still untaken waits at its end until out_tready frees the register.
// Reset clears the tick count, running status and active-note flags, loads a
// tempo of 500000 us per quarter and 480 ticks per quarter, and zero transpose.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata while idle;
// the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module midi_note_duration_tracker
  import mndt_pkg::*;
#(
  parameter int NOTE_SLOTS = NOTE_SLOTS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [TPQ_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // ev_delta[27:0], status_byte[35:28], data_one[42:36], data_two[49:43],
  // tempo_value[73:50], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // has_status[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // note_number[6:0], note_velocity[13:7], onset_time[45:14], hold_time[77:46],
  // zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;

  logic [DATA_W-1:0] note_number;
  logic [DATA_W-1:0] note_velocity;
  logic [TIME_W-1:0] onset_time;
  logic [TIME_W-1:0] hold_time;

  mndt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mndt_dp #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .ev_delta      (in_tdata[27:0]),
    .has_status    (in_tuser),
    .status_byte   (in_tdata[35:28]),
    .data_one      (in_tdata[42:36]),
    .data_two      (in_tdata[49:43]),
    .tempo_value   (in_tdata[73:50]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .onset_time    (onset_time),
    .hold_time     (hold_time),
    .cmd           (cmd),
    .sts           (sts)
  );

  assign out_tdata = {2'b00, hold_time, onset_time, note_velocity, note_number};

endmodule
